[sv/lav_pkg.sv]
// Shared constants and payload types of the look-at view matrix block.
`timescale 1ns / 1ps

package lav_pkg;

   // Fraction bits of every fixed-point value.
   localparam int FRAC_BITS = 16;
   // Width of a unit-vector component: magnitude up to 1.0 plus sign.
   localparam int VW = FRAC_BITS + 2;
   // Width of a vector that enters the normalizer (largest is up_ref cross view).
   localparam int NW = FRAC_BITS + 35;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_ref_x;
      logic signed [31:0] up_ref_y;
      logic signed [31:0] up_ref_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] entry_value;
      logic [3:0]         entry_index;
      logic               last_entry;
      logic               zero_view;
   } rsp_type;

   // Values that travel alongside a vector through the normalizer.
   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][31:0] upr;
      logic [2:0][VW-1:0] view;
      logic             zero;
      logic             hand;
   } side_type;

endpackage

[sv/look_at_view_matrix.sv]
// Look-at view matrix: two normalizers, cross and dot product stages, entry serializer.
// The time from input transfer to the first entry depends on how far each vector must
// be scaled before its square root. Each normalizer can take a new vector while earlier
// ones are still in later stages; the pace is set by the 16-step square-root unit in each
// normalizer. The sixteen entries then leave at one per cycle while rsp_ready is high.
// Reset (synchronous) empties every stage and sets handedness to right-handed.
`timescale 1ns / 1ps

module look_at_view_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lav_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lav_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int F  = lav_pkg::FRAC_BITS;
   localparam int NW = lav_pkg::NW;
   localparam int VW = lav_pkg::VW;
   localparam int UW = F + 3;
   localparam int PW = VW + 32;
   localparam int QW = 2 * VW;
   localparam int EW = UW + 32;
   localparam int RW = F + 38;
   localparam logic signed [VW-1:0] ONE  = VW'(1) << F;
   localparam logic signed [RW-1:0] MAXV = RW'(32'h7FFF_FFFF);
   localparam logic signed [RW-1:0] MINV = ~MAXV;

   typedef struct packed {
      logic               occ;
      logic [5:0][PW-1:0] p;
      lav_pkg::side_type  side;
   } x1_type;

   typedef struct packed {
      logic               occ;
      logic [5:0][QW-1:0] vr;
      logic [2:0][PW-1:0] re;
      logic [2:0][PW-1:0] ve;
      logic [2:0][VW-1:0] right;
      lav_pkg::side_type  side;
   } u1_type;

   typedef struct packed {
      logic               occ;
      logic [2:0][UW-1:0] up;
      logic [RW-1:0]      rdot;
      logic [RW-1:0]      vdot;
      logic [2:0][VW-1:0] right;
      lav_pkg::side_type  side;
   } u2_type;

   typedef struct packed {
      logic               occ;
      logic [2:0][EW-1:0] ue;
      logic [2:0][UW-1:0] up;
      logic [RW-1:0]      rdot;
      logic [RW-1:0]      vdot;
      logic [2:0][VW-1:0] right;
      lav_pkg::side_type  side;
   } t1_type;

   typedef struct packed {
      logic               occ;
      logic [RW-1:0]      udot;
      logic [2:0][UW-1:0] up;
      logic [RW-1:0]      rdot;
      logic [RW-1:0]      vdot;
      logic [2:0][VW-1:0] right;
      lav_pkg::side_type  side;
   } t2_type;

   logic hand_ff, hand_in;
   x1_type x1_ff, x1_in;
   u1_type u1_ff, u1_in;
   u2_type u2_ff, u2_in;
   t1_type t1_ff, t1_in;
   t2_type t2_ff, t2_in;
   logic              ob_vld_ff, ob_vld_in;
   logic [3:0]        ob_cnt_ff, ob_cnt_in;
   logic              ob_zero_ff, ob_zero_in;
   logic [15:0][31:0] ob_val_ff, ob_val_in;

   logic                 na_in_ready, na_out_valid, na_out_zero;
   logic [2:0][NW-1:0]   na_vec;
   logic [2:0][VW-1:0]   na_out_vec;
   lav_pkg::side_type    na_side, na_out_side;
   logic                 nb_in_ready, nb_out_valid, nb_out_zero;
   logic [2:0][NW-1:0]   nb_vec;
   logic [2:0][VW-1:0]   nb_out_vec;
   lav_pkg::side_type    nb_out_side;
   logic [2:0][VW-1:0]   right;
   logic [15:0][31:0]    ob_load_val;
   logic x1_free, u1_free, u2_free, t1_free, t2_free, ob_free, ob_last;

   function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] v);
      logic [RW-1:0] m;
      logic [RW-1:0] r;
      m = v[RW-1] ? RW'(-v) : RW'(v);
      r = (m + (RW'(1) << (F - 1))) >> F;
      rnd = v[RW-1] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
      if (v > MAXV) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v < MINV) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   assign hand_in = csr_wr_en ? csr_wr_data : hand_ff;

   // View direction: eye minus target when right-handed, target minus eye otherwise.
   always_comb begin
      if (hand_ff) begin
         na_vec[0] = NW'(33'(req_data.eye_x) - 33'(req_data.target_x));
         na_vec[1] = NW'(33'(req_data.eye_y) - 33'(req_data.target_y));
         na_vec[2] = NW'(33'(req_data.eye_z) - 33'(req_data.target_z));
      end else begin
         na_vec[0] = NW'(33'(req_data.target_x) - 33'(req_data.eye_x));
         na_vec[1] = NW'(33'(req_data.target_y) - 33'(req_data.eye_y));
         na_vec[2] = NW'(33'(req_data.target_z) - 33'(req_data.eye_z));
      end
      na_side.eye  = {req_data.eye_z, req_data.eye_y, req_data.eye_x};
      na_side.upr  = {req_data.up_ref_z, req_data.up_ref_y, req_data.up_ref_x};
      na_side.view = '0;
      na_side.zero = 1'b0;
      na_side.hand = hand_ff;
   end

   assign req_ready = na_in_ready;

   lav_norm u_view_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (na_in_ready),
      .in_vec    (na_vec),
      .in_side   (na_side),
      .out_valid (na_out_valid),
      .out_ready (x1_free),
      .out_vec   (na_out_vec),
      .out_zero  (na_out_zero),
      .out_side  (na_out_side)
   );

   assign ob_last = (ob_cnt_ff == 4'd15);
   assign ob_free = !ob_vld_ff || (rsp_ready && ob_last);
   assign t2_free = !t2_ff.occ || ob_free;
   assign t1_free = !t1_ff.occ || t2_free;
   assign u2_free = !u2_ff.occ || t1_free;
   assign u1_free = !u1_ff.occ || u2_free;
   assign x1_free = !x1_ff.occ || nb_in_ready;

   // Products for up_ref cross view.
   always_comb begin
      x1_in = x1_ff;
      if (x1_free) begin
         x1_in.occ = na_out_valid;
         x1_in.p[0] = $signed(na_out_side.upr[1]) * $signed(na_out_vec[2]);
         x1_in.p[1] = $signed(na_out_side.upr[2]) * $signed(na_out_vec[1]);
         x1_in.p[2] = $signed(na_out_side.upr[2]) * $signed(na_out_vec[0]);
         x1_in.p[3] = $signed(na_out_side.upr[0]) * $signed(na_out_vec[2]);
         x1_in.p[4] = $signed(na_out_side.upr[0]) * $signed(na_out_vec[1]);
         x1_in.p[5] = $signed(na_out_side.upr[1]) * $signed(na_out_vec[0]);
         x1_in.side      = na_out_side;
         x1_in.side.view = na_out_vec;
         x1_in.side.zero = na_out_zero;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nb_vec[i] = NW'(NW'($signed(x1_ff.p[2*i])) - NW'($signed(x1_ff.p[2*i+1])));
      end
   end

   lav_norm u_right_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x1_ff.occ),
      .in_ready  (nb_in_ready),
      .in_vec    (nb_vec),
      .in_side   (x1_ff.side),
      .out_valid (nb_out_valid),
      .out_ready (u1_free),
      .out_vec   (nb_out_vec),
      .out_zero  (nb_out_zero),
      .out_side  (nb_out_side)
   );

   // A zero cross product falls back to plus or minus the x axis.
   always_comb begin
      if (nb_out_zero) begin
         right[0] = nb_out_side.hand ? ONE : VW'(-ONE);
         right[1] = '0;
         right[2] = '0;
      end else begin
         right = nb_out_vec;
      end
   end

   always_comb begin
      u1_in = u1_ff;
      if (u1_free) begin
         u1_in.occ   = nb_out_valid;
         u1_in.vr[0] = $signed(nb_out_side.view[1]) * $signed(right[2]);
         u1_in.vr[1] = $signed(nb_out_side.view[2]) * $signed(right[1]);
         u1_in.vr[2] = $signed(nb_out_side.view[2]) * $signed(right[0]);
         u1_in.vr[3] = $signed(nb_out_side.view[0]) * $signed(right[2]);
         u1_in.vr[4] = $signed(nb_out_side.view[0]) * $signed(right[1]);
         u1_in.vr[5] = $signed(nb_out_side.view[1]) * $signed(right[0]);
         for (int i = 0; i < 3; i++) begin
            u1_in.re[i] = $signed(right[i]) * $signed(nb_out_side.eye[i]);
            u1_in.ve[i] = $signed(nb_out_side.view[i]) * $signed(nb_out_side.eye[i]);
         end
         u1_in.right = right;
         u1_in.side  = nb_out_side;
      end
   end

   always_comb begin
      u2_in = u2_ff;
      if (u2_free) begin
         u2_in.occ = u1_ff.occ;
         for (int i = 0; i < 3; i++) begin
            u2_in.up[i] = UW'(rnd(RW'($signed(u1_ff.vr[2*i])) - RW'($signed(u1_ff.vr[2*i+1]))));
         end
         u2_in.rdot = rnd(RW'($signed(u1_ff.re[0])) + RW'($signed(u1_ff.re[1]))
                          + RW'($signed(u1_ff.re[2])));
         u2_in.vdot = rnd(RW'($signed(u1_ff.ve[0])) + RW'($signed(u1_ff.ve[1]))
                          + RW'($signed(u1_ff.ve[2])));
         u2_in.right = u1_ff.right;
         u2_in.side  = u1_ff.side;
      end
   end

   always_comb begin
      t1_in = t1_ff;
      if (t1_free) begin
         t1_in.occ = u2_ff.occ;
         for (int i = 0; i < 3; i++) begin
            t1_in.ue[i] = $signed(u2_ff.up[i]) * $signed(u2_ff.side.eye[i]);
         end
         t1_in.up    = u2_ff.up;
         t1_in.rdot  = u2_ff.rdot;
         t1_in.vdot  = u2_ff.vdot;
         t1_in.right = u2_ff.right;
         t1_in.side  = u2_ff.side;
      end
   end

   always_comb begin
      t2_in = t2_ff;
      if (t2_free) begin
         t2_in.occ  = t1_ff.occ;
         t2_in.udot = rnd(RW'($signed(t1_ff.ue[0])) + RW'($signed(t1_ff.ue[1]))
                          + RW'($signed(t1_ff.ue[2])));
         t2_in.up    = t1_ff.up;
         t2_in.rdot  = t1_ff.rdot;
         t2_in.vdot  = t1_ff.vdot;
         t2_in.right = t1_ff.right;
         t2_in.side  = t1_ff.side;
      end
   end

   // Matrix in transfer order; a zero view direction clears every entry.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ob_load_val[4*i]   = 32'($signed(t2_ff.right[i]));
         ob_load_val[4*i+1] = 32'($signed(t2_ff.up[i]));
         ob_load_val[4*i+2] = 32'($signed(t2_ff.side.view[i]));
         ob_load_val[4*i+3] = '0;
      end
      ob_load_val[12] = sat32(-$signed(t2_ff.rdot));
      ob_load_val[13] = sat32(-$signed(t2_ff.udot));
      ob_load_val[14] = sat32(-$signed(t2_ff.vdot));
      ob_load_val[15] = 32'(1) << F;
      if (t2_ff.side.zero) begin
         ob_load_val = '0;
      end
   end

   // Entry serializer: the current entry always sits at the head of the shift line.
   always_comb begin
      ob_vld_in  = ob_vld_ff;
      ob_cnt_in  = ob_cnt_ff;
      ob_zero_in = ob_zero_ff;
      ob_val_in  = ob_val_ff;
      if (ob_vld_ff && rsp_ready) begin
         ob_cnt_in = ob_cnt_ff + 4'd1;
         for (int k = 0; k < 15; k++) begin
            ob_val_in[k] = ob_val_ff[k+1];
         end
         if (ob_last) begin
            ob_vld_in = 1'b0;
         end
      end
      if (ob_free && t2_ff.occ) begin
         ob_vld_in  = 1'b1;
         ob_cnt_in  = '0;
         ob_zero_in = t2_ff.side.zero;
         ob_val_in  = ob_load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff   <= 1'b1;
         x1_ff     <= '0;
         u1_ff     <= '0;
         u2_ff     <= '0;
         t1_ff     <= '0;
         t2_ff     <= '0;
         ob_vld_ff <= 1'b0;
         ob_cnt_ff <= '0;
      end else begin
         hand_ff   <= hand_in;
         x1_ff     <= x1_in;
         u1_ff     <= u1_in;
         u2_ff     <= u2_in;
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         ob_vld_ff <= ob_vld_in;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_zero_ff <= ob_zero_in;
      ob_val_ff  <= ob_val_in;
   end

   assign rsp_valid            = ob_vld_ff;
   assign rsp_data.entry_value = ob_val_ff[0];
   assign rsp_data.entry_index = ob_cnt_ff;
   assign rsp_data.last_entry  = ob_last;
   assign rsp_data.zero_view   = ob_zero_ff;

endmodule

[sv/lav_norm.sv]
// Iterative vector normalizer: scale, sum of squares, square root, three dividers.
`timescale 1ns / 1ps

module lav_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2:0][lav_pkg::NW-1:0]   in_vec,
   input  lav_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2:0][lav_pkg::VW-1:0]   out_vec,
   output logic                          out_zero,
   output lav_pkg::side_type             out_side
);

   localparam int F      = lav_pkg::FRAC_BITS;
   localparam int NW     = lav_pkg::NW;
   localparam int VW     = lav_pkg::VW;
   localparam int QSTEPS = (F + 2) / 2;
   localparam int QBITS  = 2 * QSTEPS;
   localparam int NUMW   = F + 32;
   localparam int QCW    = $clog2(QSTEPS + 1);

   typedef struct packed {
      logic               occ;
      logic [2:0][NW-1:0] u;
      logic [2:0]         neg;
      logic               zero;
      lav_pkg::side_type  side;
   } sh_type;

   typedef struct packed {
      logic               occ;
      logic [1:0]         cnt;
      logic [2:0][30:0]   u;
      logic [63:0]        acc;
      logic [2:0]         neg;
      logic               zero;
      lav_pkg::side_type  side;
   } sq_type;

   typedef struct packed {
      logic               occ;
      logic [4:0]         cnt;
      logic [63:0]        n;
      logic [35:0]        rem;
      logic [31:0]        root;
      logic [2:0][30:0]   u;
      logic [2:0]         neg;
      logic               zero;
      lav_pkg::side_type  side;
   } rt_type;

   typedef struct packed {
      logic                  occ;
      logic [QCW-1:0]        cnt;
      logic [31:0]           len;
      logic [2:0][31:0]      rem;
      logic [2:0][QBITS-1:0] lo;
      logic [2:0][QBITS-1:0] q;
      logic [2:0]            neg;
      logic                  zero;
      lav_pkg::side_type     side;
   } dv_type;

   sh_type sh_ff, sh_in;
   sq_type sq_ff, sq_in;
   rt_type rt_ff, rt_in;
   dv_type dv_ff, dv_in;

   logic any_hi8, any_hi, all_lo8, all_lo;
   logic sh_done, sq_done, rt_done, dv_done;
   logic sh_free, sq_free, rt_free, dv_free;
   logic sh_take, sq_take, rt_take, dv_take;
   logic [30:0] sq_sel;
   logic [67:0] rt_s1, rt_s2;
   logic [32:0] dv_a [3];
   logic [32:0] dv_b [3];
   logic [NUMW-1:0] dv_num [3];

   // One step of the digit-by-digit square root: brings in two bits of the radicand.
   function automatic logic [67:0] root_step(input logic [35:0] rem, input logic [31:0] root,
                                             input logic [1:0] pair);
      logic [35:0] r;
      logic [35:0] t;
      r = {rem[33:0], pair};
      t = {2'b00, root, 2'b01};
      if (r >= t) begin
         root_step = {r - t, root[30:0], 1'b1};
      end else begin
         root_step = {r, root[30:0], 1'b0};
      end
   endfunction

   // One step of restoring division: quotient bit on top, remainder below.
   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] len,
                                            input logic bit_in);
      logic [32:0] r;
      r = {rem, bit_in};
      if (r >= {1'b0, len}) begin
         div_step = {1'b1, 32'(r - {1'b0, len})};
      end else begin
         div_step = {1'b0, r[31:0]};
      end
   endfunction

   always_comb begin
      any_hi8 = 1'b0;
      any_hi  = 1'b0;
      all_lo8 = 1'b1;
      all_lo  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (sh_ff.u[i][NW-1:38] != '0) any_hi8 = 1'b1;
         if (sh_ff.u[i][NW-1:31] != '0) any_hi = 1'b1;
         if (sh_ff.u[i][NW-1:22] != '0) all_lo8 = 1'b0;
         if (sh_ff.u[i][NW-1:30] != '0) all_lo = 1'b0;
      end
   end

   assign sh_done = sh_ff.occ && (sh_ff.zero || (!any_hi && !all_lo));
   assign sq_done = sq_ff.occ && (sq_ff.cnt == 2'd3);
   assign rt_done = rt_ff.occ && (rt_ff.cnt == 5'd16);
   assign dv_done = dv_ff.occ && (dv_ff.cnt == QCW'(QSTEPS));

   assign dv_take = dv_done && out_ready;
   assign dv_free = !dv_ff.occ || dv_take;
   assign rt_take = rt_done && dv_free;
   assign rt_free = !rt_ff.occ || rt_take;
   assign sq_take = sq_done && rt_free;
   assign sq_free = !sq_ff.occ || sq_take;
   assign sh_take = sh_done && sq_free;
   assign sh_free = !sh_ff.occ || sh_take;
   assign in_ready = sh_free;

   // Scale the magnitudes until the largest lies in [2^30, 2^31).
   always_comb begin
      sh_in = sh_ff;
      if (sh_take) begin
         sh_in.occ = 1'b0;
      end else if (sh_ff.occ && !sh_done) begin
         for (int i = 0; i < 3; i++) begin
            if (any_hi8) begin
               sh_in.u[i] = sh_ff.u[i] >> 8;
            end else if (any_hi) begin
               sh_in.u[i] = sh_ff.u[i] >> 1;
            end else if (all_lo8) begin
               sh_in.u[i] = sh_ff.u[i] << 8;
            end else begin
               sh_in.u[i] = sh_ff.u[i] << 1;
            end
         end
      end
      if (in_valid && sh_free) begin
         sh_in.occ  = 1'b1;
         sh_in.zero = (in_vec == '0);
         sh_in.side = in_side;
         for (int i = 0; i < 3; i++) begin
            sh_in.neg[i] = in_vec[i][NW-1];
            sh_in.u[i]   = in_vec[i][NW-1] ? NW'(-in_vec[i]) : in_vec[i];
         end
      end
   end

   always_comb begin
      unique case (sq_ff.cnt)
         2'd0:    sq_sel = sq_ff.u[0];
         2'd1:    sq_sel = sq_ff.u[1];
         2'd2:    sq_sel = sq_ff.u[2];
         default: sq_sel = '0;
      endcase
   end

   // Sum of squares, one component per cycle on a single multiplier.
   always_comb begin
      sq_in = sq_ff;
      if (sq_take) begin
         sq_in.occ = 1'b0;
      end else if (sq_ff.occ && !sq_done) begin
         sq_in.acc = sq_ff.acc + 64'(sq_sel * sq_sel);
         sq_in.cnt = sq_ff.cnt + 2'd1;
      end
      if (sh_take) begin
         sq_in.occ  = 1'b1;
         sq_in.cnt  = '0;
         sq_in.acc  = '0;
         sq_in.neg  = sh_ff.neg;
         sq_in.zero = sh_ff.zero;
         sq_in.side = sh_ff.side;
         for (int i = 0; i < 3; i++) begin
            sq_in.u[i] = sh_ff.u[i][30:0];
         end
      end
   end

   assign rt_s1 = root_step(rt_ff.rem, rt_ff.root, rt_ff.n[63:62]);
   assign rt_s2 = root_step(rt_s1[67:32], rt_s1[31:0], rt_ff.n[61:60]);

   // Square root, two result bits per cycle.
   always_comb begin
      rt_in = rt_ff;
      if (rt_take) begin
         rt_in.occ = 1'b0;
      end else if (rt_ff.occ && !rt_done) begin
         rt_in.rem  = rt_s2[67:32];
         rt_in.root = rt_s2[31:0];
         rt_in.n    = rt_ff.n << 4;
         rt_in.cnt  = rt_ff.cnt + 5'd1;
      end
      if (sq_take) begin
         rt_in.occ  = 1'b1;
         rt_in.cnt  = '0;
         rt_in.n    = sq_ff.acc;
         rt_in.rem  = '0;
         rt_in.root = '0;
         rt_in.u    = sq_ff.u;
         rt_in.neg  = sq_ff.neg;
         rt_in.zero = sq_ff.zero;
         rt_in.side = sq_ff.side;
      end
   end

   // Three dividers in parallel, two quotient bits per cycle, rounded by len/2.
   always_comb begin
      dv_in = dv_ff;
      for (int i = 0; i < 3; i++) begin
         dv_a[i]   = div_step(dv_ff.rem[i], dv_ff.len, dv_ff.lo[i][QBITS-1]);
         dv_b[i]   = div_step(dv_a[i][31:0], dv_ff.len, dv_ff.lo[i][QBITS-2]);
         dv_num[i] = (NUMW'(rt_ff.u[i]) << F) + NUMW'(rt_ff.root[31:1]);
      end
      if (dv_take) begin
         dv_in.occ = 1'b0;
      end else if (dv_ff.occ && !dv_done) begin
         dv_in.cnt = dv_ff.cnt + QCW'(1);
         for (int i = 0; i < 3; i++) begin
            dv_in.rem[i] = dv_b[i][31:0];
            dv_in.lo[i]  = dv_ff.lo[i] << 2;
            dv_in.q[i]   = {dv_ff.q[i][QBITS-3:0], dv_a[i][32], dv_b[i][32]};
         end
      end
      if (rt_take) begin
         dv_in.occ  = 1'b1;
         dv_in.cnt  = '0;
         dv_in.len  = rt_ff.root;
         dv_in.neg  = rt_ff.neg;
         dv_in.zero = rt_ff.zero;
         dv_in.side = rt_ff.side;
         for (int i = 0; i < 3; i++) begin
            dv_in.rem[i] = 32'(dv_num[i] >> QBITS);
            dv_in.lo[i]  = dv_num[i][QBITS-1:0];
            dv_in.q[i]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff <= '0;
         sq_ff <= '0;
         rt_ff <= '0;
         dv_ff <= '0;
      end else begin
         sh_ff <= sh_in;
         sq_ff <= sq_in;
         rt_ff <= rt_in;
         dv_ff <= dv_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_vec[i] = dv_ff.neg[i] ? VW'(-VW'(dv_ff.q[i])) : VW'(dv_ff.q[i]);
      end
   end

   assign out_valid = dv_done;
   assign out_zero  = dv_ff.zero;
   assign out_side  = dv_ff.side;

endmodule
